// File: hw/rtl/brpt_pkg.sv
// ----------------------------------------------------------------------------
// brpt_pkg
// Shared types and constants for the blended rigid point transform.
// ----------------------------------------------------------------------------
package brpt_pkg;

    localparam int NUM_TRANSFORMS_DEF = 4;
    localparam int FRAC_BITS_DEF      = 16;
    localparam int WEIGHT_FIELDS      = 4;
    localparam int ENTRIES            = 12;   // 3x4 row-major per transform
    localparam int SLOT_W             = 6;
    localparam int VAL_W              = 32;
    localparam int WGT_W              = 17;
    localparam int PROD_W             = 49;   // 32 x 18 signed
    localparam int BLEND_W            = 52;   // sum of up to 8 products
    localparam int SPLIT              = 26;   // low part of a blended entry
    localparam int PART_W             = 60;   // 27 x 32 partial product
    localparam int ROW_W              = 62;   // sum of three partials
    localparam int ACC_W              = 92;   // exact row sum at scale 2^(3F)
    localparam int Q_DEPTH            = 2;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_POINT = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd                    cmd;
        logic [SLOT_W-1:0]       slot;
        logic signed [VAL_W-1:0] value;
        logic signed [VAL_W-1:0] px;
        logic signed [VAL_W-1:0] py;
        logic signed [VAL_W-1:0] pz;
        logic [WGT_W-1:0]        w0;
        logic [WGT_W-1:0]        w1;
        logic [WGT_W-1:0]        w2;
        logic [WGT_W-1:0]        w3;
    } t_q_entry;

endpackage

// File: hw/rtl/brpt_front.sv
// ----------------------------------------------------------------------------
// brpt_front
// Accepts input beats, drops writes beyond the table, and queues the rest.
// ----------------------------------------------------------------------------
module brpt_front #(
    parameter int NUM_TRANSFORMS = brpt_pkg::NUM_TRANSFORMS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  brpt_pkg::t_q_entry                    i_entry,
    output logic                                  o_q_valid,
    output brpt_pkg::t_q_entry                    o_q_entry,
    input  logic                                  i_q_pop
);
    localparam int TW = NUM_TRANSFORMS * brpt_pkg::ENTRIES;

    brpt_pkg::t_q_entry r_mem [brpt_pkg::Q_DEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       accept, keep, push, pop;

    assign o_in_ready = (r_cnt != 2'(brpt_pkg::Q_DEPTH));
    assign accept     = i_in_valid && o_in_ready;
    assign keep       = (i_entry.cmd == brpt_pkg::CMD_POINT) ||
                        ({1'b0, i_entry.slot} < 7'(TW));
    assign push       = accept && keep;
    assign pop        = i_q_pop && (r_cnt != 2'd0);
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_entry  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_entry;
    end

endmodule

// File: hw/rtl/brpt_back.sv
// ----------------------------------------------------------------------------
// brpt_back
// Owns the transform table and runs the blend pipeline to the output register.
// ----------------------------------------------------------------------------
module brpt_back #(
    parameter int NUM_TRANSFORMS = brpt_pkg::NUM_TRANSFORMS_DEF,
    parameter int FRAC_BITS      = brpt_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_q_valid,
    input  brpt_pkg::t_q_entry                    i_q_entry,
    output logic                                  o_q_pop,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [brpt_pkg::VAL_W-1:0]     o_out_x,
    output logic signed [brpt_pkg::VAL_W-1:0]     o_out_y,
    output logic signed [brpt_pkg::VAL_W-1:0]     o_out_z,
    output logic                                  o_saturated
);
    localparam int NT = NUM_TRANSFORMS;
    localparam int NE = brpt_pkg::ENTRIES;
    localparam int TW = NT * NE;
    localparam int VW = brpt_pkg::VAL_W;
    localparam int AW = brpt_pkg::ACC_W;

    logic signed [VW-1:0] r_tab [TW];

    logic signed [brpt_pkg::PROD_W-1:0]  r_prod [NT][NE];
    logic signed [brpt_pkg::BLEND_W-1:0] r_m    [NE];
    logic signed [brpt_pkg::PART_W-1:0]  r_lo   [3][3];
    logic signed [brpt_pkg::PART_W-1:0]  r_hi   [3][3];
    logic signed [brpt_pkg::BLEND_W-1:0] r_t3   [3];
    logic signed [brpt_pkg::BLEND_W-1:0] r_t4   [3];
    logic signed [brpt_pkg::ROW_W-1:0]   r_slo  [3];
    logic signed [brpt_pkg::ROW_W-1:0]   r_shi  [3];
    logic signed [AW-1:0]                r_acc  [3];
    logic signed [VW-1:0]                r_p1   [3];
    logic signed [VW-1:0]                r_p2   [3];
    logic signed [VW-1:0]                r_res  [3];
    logic                                r_sat;
    logic [5:1]                          r_v;
    logic                                r_v6;

    logic signed [brpt_pkg::PROD_W-1:0]  n_prod [NT][NE];
    logic signed [brpt_pkg::BLEND_W-1:0] n_m    [NE];
    logic signed [VW-1:0]                n_res  [3];
    logic                                n_sat;
    logic [brpt_pkg::WGT_W-1:0]          wsel   [NT];
    logic                                en, pop, take_pt;

    assign en      = !r_v6 || i_out_ready;
    assign pop     = en && i_q_valid;
    assign take_pt = pop && (i_q_entry.cmd == brpt_pkg::CMD_POINT);
    assign o_q_pop = en;

    always_comb begin
        for (int k = 0; k < NT; k++) begin
            case (k)
                0:       wsel[k] = i_q_entry.w0;
                1:       wsel[k] = i_q_entry.w1;
                2:       wsel[k] = i_q_entry.w2;
                3:       wsel[k] = i_q_entry.w3;
                default: wsel[k] = '0;
            endcase
            for (int e = 0; e < NE; e++)
                n_prod[k][e] = brpt_pkg::PROD_W'(r_tab[k*NE+e] * $signed({1'b0, wsel[k]}));
        end
        for (int e = 0; e < NE; e++) begin
            n_m[e] = '0;
            for (int k = 0; k < NT; k++)
                n_m[e] = n_m[e] + brpt_pkg::BLEND_W'(r_prod[k][e]);
        end
        n_sat = 1'b0;
        for (int r = 0; r < 3; r++) begin
            logic signed [AW-1:0] sh;
            sh = r_acc[r] >>> (2 * FRAC_BITS);
            if (sh > AW'(64'sh7FFF_FFFF)) begin
                n_res[r] = 32'sh7FFF_FFFF;
                n_sat    = 1'b1;
            end else if (sh < -AW'(64'sh8000_0000)) begin
                n_res[r] = 32'sh8000_0000;
                n_sat    = 1'b1;
            end else begin
                n_res[r] = sh[VW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < TW; e++) r_tab[e] <= '0;
            r_v  <= '0;
            r_v6 <= 1'b0;
        end else begin
            if (pop && (i_q_entry.cmd == brpt_pkg::CMD_WRITE)) begin
                for (int e = 0; e < TW; e++)
                    if (i_q_entry.slot == brpt_pkg::SLOT_W'(e)) r_tab[e] <= i_q_entry.value;
            end
            if (en) begin
                r_v  <= {r_v[4:1], take_pt};
                r_v6 <= r_v[5];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod <= n_prod;
            r_p1   <= '{i_q_entry.px, i_q_entry.py, i_q_entry.pz};
            r_m    <= n_m;
            r_p2   <= r_p1;
            for (int r = 0; r < 3; r++) begin
                for (int j = 0; j < 3; j++) begin
                    r_lo[r][j] <= brpt_pkg::PART_W'(
                        $signed({1'b0, r_m[4*r+j][brpt_pkg::SPLIT-1:0]}) * r_p2[j]);
                    r_hi[r][j] <= brpt_pkg::PART_W'(
                        $signed(r_m[4*r+j][brpt_pkg::BLEND_W-1:brpt_pkg::SPLIT]) * r_p2[j]);
                end
                r_t3[r]  <= r_m[4*r+3];
                r_t4[r]  <= r_t3[r];
                r_slo[r] <= brpt_pkg::ROW_W'(r_lo[r][0]) + brpt_pkg::ROW_W'(r_lo[r][1])
                          + brpt_pkg::ROW_W'(r_lo[r][2]);
                r_shi[r] <= brpt_pkg::ROW_W'(r_hi[r][0]) + brpt_pkg::ROW_W'(r_hi[r][1])
                          + brpt_pkg::ROW_W'(r_hi[r][2]);
                r_acc[r] <= (AW'(r_shi[r]) <<< brpt_pkg::SPLIT) + AW'(r_slo[r])
                          + (AW'(r_t4[r]) <<< FRAC_BITS)
                          + (AW'(1) <<< (2 * FRAC_BITS - 1));
            end
            r_res <= n_res;
            r_sat <= n_sat;
        end
    end

    assign o_out_valid = r_v6;
    assign o_out_x     = r_res[0];
    assign o_out_y     = r_res[1];
    assign o_out_z     = r_res[2];
    assign o_saturated = r_sat;

endmodule

// File: hw/rtl/blended_rigid_point_transform_top.sv
// ----------------------------------------------------------------------------
// blended_rigid_point_transform_top
// Linear blend of a point through a table of rigid 3x4 transforms.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats with cmd = write load one Q16.16 word of the transform table
//   (slot = transform * 12 + entry); writes beyond the table are dropped and
//   give no result. Beats with cmd = point carry a point and one weight per
//   transform and give one result beat: sum of w_k * (R_k * p + t_k), rounded
//   to nearest and saturated, with o_saturated flagging any clipped axis.
//   Throughput is one beat per cycle while the receiver does not stall; a
//   point result passes through the queue and then through the six-stage
//   multiply/sum pipeline whose last stage is the output register. Table
//   writes take effect in order with points.
//   Reset clears the table to zero and empties the pipeline.
//   When the receiver stalls the whole back pipeline holds; the two-entry
//   queue keeps taking beats until full, then o_in_ready drops.
// ----------------------------------------------------------------------------
module blended_rigid_point_transform_top #(
    parameter int NUM_TRANSFORMS = brpt_pkg::NUM_TRANSFORMS_DEF,
    parameter int FRAC_BITS      = brpt_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_cmd,
    input  logic [brpt_pkg::SLOT_W-1:0]       i_table_slot,
    input  logic signed [brpt_pkg::VAL_W-1:0] i_table_value,
    input  logic signed [brpt_pkg::VAL_W-1:0] i_point_x,
    input  logic signed [brpt_pkg::VAL_W-1:0] i_point_y,
    input  logic signed [brpt_pkg::VAL_W-1:0] i_point_z,
    input  logic [brpt_pkg::WGT_W-1:0]        i_weight_0,
    input  logic [brpt_pkg::WGT_W-1:0]        i_weight_1,
    input  logic [brpt_pkg::WGT_W-1:0]        i_weight_2,
    input  logic [brpt_pkg::WGT_W-1:0]        i_weight_3,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [brpt_pkg::VAL_W-1:0] o_out_x,
    output logic signed [brpt_pkg::VAL_W-1:0] o_out_y,
    output logic signed [brpt_pkg::VAL_W-1:0] o_out_z,
    output logic                              o_saturated
);
    brpt_pkg::t_q_entry in_entry, q_entry;
    logic               q_valid, q_pop;

    assign in_entry = '{cmd: brpt_pkg::t_cmd'(i_cmd), slot: i_table_slot,
                        value: i_table_value, px: i_point_x, py: i_point_y,
                        pz: i_point_z, w0: i_weight_0, w1: i_weight_1,
                        w2: i_weight_2, w3: i_weight_3};

    brpt_front #(.NUM_TRANSFORMS(NUM_TRANSFORMS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_entry(in_entry),
        .o_q_valid(q_valid), .o_q_entry(q_entry), .i_q_pop(q_pop)
    );

    brpt_back #(.NUM_TRANSFORMS(NUM_TRANSFORMS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .i_q_entry(q_entry), .o_q_pop(q_pop),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_out_x(o_out_x), .o_out_y(o_out_y), .o_out_z(o_out_z),
        .o_saturated(o_saturated)
    );

endmodule

// File: hw/rtl/brpt_checker.sv
// ----------------------------------------------------------------------------
// brpt_checker
// Port-level checks for the blended rigid point transform.
// ----------------------------------------------------------------------------
module brpt_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic signed [brpt_pkg::VAL_W-1:0] o_out_x,
    input logic signed [brpt_pkg::VAL_W-1:0] o_out_y,
    input logic signed [brpt_pkg::VAL_W-1:0] o_out_z,
    input logic                              o_saturated
);
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("result beat right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_x)
            && $stable(o_out_y) && $stable(o_out_z) && $stable(o_saturated))
        else $error("stalled result beat changed");

    a_sat_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |->
            o_out_x == 32'sh7FFF_FFFF || o_out_x == 32'sh8000_0000 ||
            o_out_y == 32'sh7FFF_FFFF || o_out_y == 32'sh8000_0000 ||
            o_out_z == 32'sh7FFF_FFFF || o_out_z == 32'sh8000_0000)
        else $error("saturated flag without a clipped axis");

endmodule

bind blended_rigid_point_transform_top brpt_checker u_brpt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready), .o_out_x(o_out_x), .o_out_y(o_out_y),
    .o_out_z(o_out_z), .o_saturated(o_saturated)
);

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the blended rigid point transform: loads transform
// tables, streams weighted points with random sender bursts and receiver
// stalls, and compares every result beat against an exact-arithmetic model.
// ----------------------------------------------------------------------------
class blend_scoreboard;
    logic signed [31:0] xform_words[48];
    logic [31:0]        exp_x[$];
    logic [31:0]        exp_y[$];
    logic [31:0]        exp_z[$];
    logic               exp_sat[$];
    int                 errors;

    function void clear_table();
        foreach (xform_words[i]) xform_words[i] = '0;
        errors = 0;
    endfunction

    function logic [31:0] round_sat(logic signed [127:0] acc, ref logic sat);
        logic signed [127:0] r;
        r = (acc + (128'sd1 <<< 31)) >>> 32;
        if (r > 128'sd2147483647) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (r < -128'sd2147483648) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return r[31:0];
    endfunction

    function void note_beat(brpt_pkg::t_cmd cmd, logic [5:0] slot, logic signed [31:0] val,
                            logic signed [31:0] p[3], logic [16:0] w[4]);
        logic signed [127:0] acc[3];
        logic signed [127:0] term;
        logic                sat;
        if (cmd == brpt_pkg::CMD_WRITE) begin
            if (slot < 48) xform_words[slot] = val;
            return;
        end
        sat = 1'b0;
        for (int r = 0; r < 3; r++) begin
            acc[r] = '0;
            for (int k = 0; k < 4; k++) begin
                term = 128'(xform_words[k*12+r*4+3]) <<< 16;
                for (int j = 0; j < 3; j++)
                    term += 128'(xform_words[k*12+r*4+j]) * 128'(p[j]);
                acc[r] += term * $signed({111'd0, w[k]});
            end
        end
        exp_x.push_back(round_sat(acc[0], sat));
        exp_y.push_back(round_sat(acc[1], sat));
        exp_z.push_back(round_sat(acc[2], sat));
        exp_sat.push_back(sat);
    endfunction

    function void check_beat(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic s);
        logic [31:0] ex, ey, ez;
        logic        es;
        if (exp_x.size() == 0) begin
            $display("%0t: unexpected result beat x=%h y=%h z=%h", $time, x, y, z);
            errors++;
            return;
        end
        ex = exp_x.pop_front();
        ey = exp_y.pop_front();
        ez = exp_z.pop_front();
        es = exp_sat.pop_front();
        if (x !== ex) begin
            $display("%0t: out_x expected %h actual %h", $time, ex, x);
            errors++;
        end
        if (y !== ey) begin
            $display("%0t: out_y expected %h actual %h", $time, ey, y);
            errors++;
        end
        if (z !== ez) begin
            $display("%0t: out_z expected %h actual %h", $time, ez, z);
            errors++;
        end
        if (s !== es) begin
            $display("%0t: saturated expected %b actual %b", $time, es, s);
            errors++;
        end
    endfunction

    function int pending();
        return exp_x.size();
    endfunction
endclass

module tb_top;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_cmd = 1'b0;
    logic [5:0]         i_table_slot = '0;
    logic signed [31:0] i_table_value = '0;
    logic signed [31:0] i_point_x = '0;
    logic signed [31:0] i_point_y = '0;
    logic signed [31:0] i_point_z = '0;
    logic [16:0]        i_weight_0 = '0;
    logic [16:0]        i_weight_1 = '0;
    logic [16:0]        i_weight_2 = '0;
    logic [16:0]        i_weight_3 = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [31:0] o_out_x;
    logic signed [31:0] o_out_y;
    logic signed [31:0] o_out_z;
    logic               o_saturated;

    blend_scoreboard blend_sb;
    int              cycle_count = 0;
    bit              long_hold = 1'b0;
    bit              stall_enable = 1'b0;

    always #10 i_clk = ~i_clk;

    blended_rigid_point_transform_top DUT (.*);

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: a stall pattern of its own, plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (long_hold) begin
            i_out_ready <= 1'b0;
        end else if (stall_enable) begin
            i_out_ready <= ($urandom_range(0, 3) != 0);
        end else begin
            i_out_ready <= 1'b1;
        end
        if (i_rst_n && o_out_valid && i_out_ready)
            blend_sb.check_beat(o_out_x, o_out_y, o_out_z, o_saturated);
    end

    function automatic logic signed [31:0] rand_val();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $signed($urandom_range(0, 131072)) - 32'sd65536;
            3: return $signed($urandom_range(0, 2097152)) - 32'sd1048576;
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic logic [16:0] rand_weight();
        case ($urandom_range(0, 5))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'h1FFFF;
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic send_beat(brpt_pkg::t_cmd cmd, logic [5:0] slot, logic signed [31:0] val,
                             logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [31:0] pz, logic [16:0] w0, logic [16:0] w1,
                             logic [16:0] w2, logic [16:0] w3);
        logic signed [31:0] p[3];
        logic [16:0]        w[4];
        p = '{px, py, pz};
        w = '{w0, w1, w2, w3};
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_table_slot  <= slot;
        i_table_value <= val;
        i_point_x     <= px;
        i_point_y     <= py;
        i_point_z     <= pz;
        i_weight_0    <= w0;
        i_weight_1    <= w1;
        i_weight_2    <= w2;
        i_weight_3    <= w3;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        blend_sb.note_beat(cmd, slot, val, p, w);
    endtask

    task automatic idle_sender(int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_write(logic [5:0] slot, logic signed [31:0] val);
        send_beat(brpt_pkg::CMD_WRITE, slot, val, rand_val(), rand_val(), rand_val(),
                  rand_weight(), rand_weight(), rand_weight(), rand_weight());
    endtask

    task automatic send_point(logic signed [31:0] px, logic signed [31:0] py,
                              logic signed [31:0] pz, logic [16:0] w0, logic [16:0] w1,
                              logic [16:0] w2, logic [16:0] w3);
        send_beat(brpt_pkg::CMD_POINT, 6'($urandom()), rand_val(), px, py, pz,
                  w0, w1, w2, w3);
    endtask

    task automatic send_rand_point();
        send_point(rand_val(), rand_val(), rand_val(),
                   rand_weight(), rand_weight(), rand_weight(), rand_weight());
    endtask

    // near-rigid transform: small rotation entries, moderate translation
    task automatic load_rigid_xform(int k);
        for (int e = 0; e < 12; e++) begin
            if (e % 4 == 3)
                send_write(6'(k*12+e), $signed($urandom_range(0, 1 << 24)) - 32'sd8388608);
            else
                send_write(6'(k*12+e), $signed($urandom_range(0, 131072)) - 32'sd65536);
        end
    endtask

    task automatic drain();
        idle_sender(1);
        while (blend_sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    initial begin
        int sent;
        int burst;
        blend_sb = new();
        blend_sb.clear_table();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, identity, extremes, unaddressable slots
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 17'd65536, 17'd65536, 17'd65536, 17'h1FFFF);
        for (int k = 0; k < 4; k++) begin
            send_write(6'(k*12+0), 32'sh0001_0000);
            send_write(6'(k*12+5), 32'sh0001_0000);
            send_write(6'(k*12+10), 32'sh0001_0000);
        end
        send_write(6'd3, 32'sh7FFF_FFFF);
        send_write(6'd48, 32'sh1234_5678);
        send_write(6'd63, 32'sh8000_0000);
        send_point(32'sh0001_8000, -32'sh0000_8000, 32'sh7FFF_FFFF,
                   17'd65536, 17'd0, 17'd0, 17'd0);
        send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                   17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                   17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
        send_point(1, -1, 0, 17'd1, 17'd1, 17'd1, 17'd1);
        send_point(0, 0, 0, 17'd0, 17'd0, 17'd0, 17'd0);
        drain();

        // long receiver hold while the sender keeps offering
        long_hold = 1'b1;
        fork
            begin
                repeat (12) send_rand_point();
                idle_sender(0);
            end
            repeat (60) @(posedge i_clk);
        join_any
        repeat (60) @(posedge i_clk);
        long_hold = 1'b0;
        wait fork;
        drain();

        // random: batches of table reload and stray single writes, then bursts of points
        stall_enable = 1'b1;
        sent = 0;
        while (sent < 500) begin
            if ($urandom_range(0, 3) == 0) begin
                load_rigid_xform($urandom_range(0, 3));
                sent += 12;
            end
            if ($urandom_range(0, 5) == 0) begin
                send_write(6'($urandom()), rand_val());
                sent++;
            end
            burst = $urandom_range(1, 20);
            repeat (burst) send_rand_point();
            sent += burst;
            if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 8));
            if ($urandom_range(0, 15) == 0) stall_enable = !stall_enable;
        end
        stall_enable = 1'b0;
        drain();

        if (blend_sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// File: sim.f
hw/rtl/brpt_pkg.sv
hw/rtl/brpt_front.sv
hw/rtl/brpt_back.sv
hw/rtl/blended_rigid_point_transform_top.sv
hw/rtl/brpt_checker.sv
test/tb_top.sv
